### sv/chap_md5_response_check_macros.svh
// assertion helpers for the top-level rtl, clock and reset names fixed by the house style
`ifndef CHAP_MD5_RESPONSE_CHECK_MACROS_SVH
`define CHAP_MD5_RESPONSE_CHECK_MACROS_SVH

// same-cycle implication, checked out of reset
`define CMD5_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cmd5 check failed");

// next-cycle implication, checked out of reset
`define CMD5_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cmd5 check failed");

`endif

### sv/cmd5_pkg.sv
package cmd5_pkg;

    localparam int SECRET_BYTES    = 8;
    localparam int CHALLENGE_BYTES = 16;
    localparam int MSG_BYTES       = 1 + SECRET_BYTES + CHALLENGE_BYTES;
    localparam int ROUNDS          = 64;
    localparam logic [15:0] MSG_BITS = 16'(MSG_BYTES * 8);

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_IDENTIFIER     = 3'd0,
        REG_CHALLENGE_HIGH = 3'd1,
        REG_CHALLENGE_LOW  = 3'd2,
        REG_EXPECTED_HIGH  = 3'd3,
        REG_EXPECTED_LOW   = 3'd4
    } reg_index_t;

    // round function of each group of sixteen rounds
    typedef enum logic [1:0] {
        FN_F = 2'd0,
        FN_G = 2'd1,
        FN_H = 2'd2,
        FN_I = 2'd3
    } round_fn_t;

    typedef struct packed {
        logic [31:0] k;
        logic [4:0]  shift;
        logic [3:0]  g;
        round_fn_t   fn;
    } round_cfg_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [63:0] secret;
    } md5_state_t;

    typedef struct packed {
        logic       valid;
        md5_state_t st;
    } stage_t;

    typedef struct packed {
        logic [7:0]  identifier;
        logic [63:0] challenge_high;
        logic [63:0] challenge_low;
    } msg_cfg_t;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;

    localparam logic [31:0] MD5_K [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_R [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // constants of one round: additive constant, rotation, message word, function
    function automatic round_cfg_t round_info(input logic [5:0] i);
        round_cfg_t r;
        r.k     = MD5_K[i];
        r.shift = MD5_R[{i[5:4], i[1:0]}];
        r.fn    = round_fn_t'(i[5:4]);
        case (i[5:4])
            2'd0:    r.g = i[3:0];
            2'd1:    r.g = 4'(i[3:0] * 4'd5 + 4'd1);
            2'd2:    r.g = 4'(i[3:0] * 4'd3 + 4'd5);
            default: r.g = 4'(i[3:0] * 4'd7);
        endcase
        return r;
    endfunction

    // one little-endian word of the padded block: identifier, secret, challenge, pad, length
    function automatic logic [31:0] msg_word(input msg_cfg_t cfg, input logic [63:0] secret,
                                             input logic [3:0] w);
        logic [511:0] blk;
        int c;
        blk = '0;
        for (int p = 0; p < 64; p++) begin
            c = p - 1 - SECRET_BYTES;
            if (p == 0) begin
                blk[7:0] = cfg.identifier;
            end else if (p <= SECRET_BYTES) begin
                blk[8*p +: 8] = secret[63 - 8*(p-1) -: 8];
            end else if (p < MSG_BYTES) begin
                if (c < 8) begin
                    blk[8*p +: 8] = cfg.challenge_high[63 - 8*c -: 8];
                end else begin
                    blk[8*p +: 8] = cfg.challenge_low[63 - 8*(c-8) -: 8];
                end
            end else if (p == MSG_BYTES) begin
                blk[8*p +: 8] = 8'h80;
            end else if (p == 56) begin
                blk[8*p +: 8] = MSG_BITS[7:0];
            end else if (p == 57) begin
                blk[8*p +: 8] = MSG_BITS[15:8];
            end
        end
        return blk[{w, 5'd0} +: 32];
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

### sv/chap_md5_response_check.sv
// chap-md5 response check, authenticator side. each transaction on the s_ side carries an
// eight-byte candidate secret (first byte in bits 63:56); the block hashes identifier, secret
// and the sixteen challenge bytes as one padded md5 block and returns the digest with a flag
// that is high when it equals the expected response. a chain of 64 round cells, one per md5
// round, and an output register take a new secret every cycle while the m_ side does not
// stall; a stall freezes the whole chain, so s_tready follows !m_tvalid || m_tready. the cfg_
// port writes identifier, challenge and expected response (index 0 identifier, 1/2 challenge
// high/low, 3/4 expected high/low, others ignored); all reset to zero. the user must write
// them only while no transaction is in flight; the block does not enforce this.
`include "chap_md5_response_check_macros.svh"

module chap_md5_response_check
    import cmd5_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,

    // candidate secrets
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [63:0] secret

    // digests
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] digest_high, [127:64] digest_low
    output logic         m_tuser    // [0] matched
);

    logic [7:0]   identifier_reg;
    logic [63:0]  challenge_high_reg;
    logic [63:0]  challenge_low_reg;
    logic [63:0]  expected_high_reg;
    logic [63:0]  expected_low_reg;

    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;
    logic         m_tuser_reg;
    logic [127:0] m_tdata_next;
    logic         m_tuser_next;

    logic         advance;
    msg_cfg_t     mcfg;
    stage_t       link [ROUNDS+1];

    logic [31:0]  h0;
    logic [31:0]  h1;
    logic [31:0]  h2;
    logic [31:0]  h3;
    logic [63:0]  digest_high;
    logic [63:0]  digest_low;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            identifier_reg     <= '0;
            challenge_high_reg <= '0;
            challenge_low_reg  <= '0;
            expected_high_reg  <= '0;
            expected_low_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IDENTIFIER:     identifier_reg     <= cfg_data[7:0];
                REG_CHALLENGE_HIGH: challenge_high_reg <= cfg_data;
                REG_CHALLENGE_LOW:  challenge_low_reg  <= cfg_data;
                REG_EXPECTED_HIGH:  expected_high_reg  <= cfg_data;
                REG_EXPECTED_LOW:   expected_low_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign mcfg.identifier     = identifier_reg;
    assign mcfg.challenge_high = challenge_high_reg;
    assign mcfg.challenge_low  = challenge_low_reg;

    // the chain moves whenever the output register is free or being emptied
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // chain head: initial md5 state plus the incoming secret
    assign link[0].valid     = s_tvalid;
    assign link[0].st.a      = H0;
    assign link[0].st.b      = H1;
    assign link[0].st.c      = H2;
    assign link[0].st.d      = H3;
    assign link[0].st.secret = s_tdata;

    for (genvar i = 0; i < ROUNDS; i++) begin : g_round
        cmd5_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .rcfg      (round_info(6'(i))),
            .mcfg      (mcfg),
            .stage_in  (link[i]),
            .stage_out (link[i+1])
        );
    end

    // final feed-forward, byte order of the digest and the compare
    always_comb begin
        h0           = H0 + link[ROUNDS].st.a;
        h1           = H1 + link[ROUNDS].st.b;
        h2           = H2 + link[ROUNDS].st.c;
        h3           = H3 + link[ROUNDS].st.d;
        digest_high  = {bswap32(h0), bswap32(h1)};
        digest_low   = {bswap32(h2), bswap32(h3)};
        m_tdata_next = {digest_low, digest_high};
        m_tuser_next = (digest_high == expected_high_reg) && (digest_low == expected_low_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= link[ROUNDS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // an accepted secret lands in the first round cell
    `CMD5_ASSERT_NEXT(a_head_loaded, s_tvalid && s_tready, link[1].valid)
    // the last round cell hands its transaction to the output register
    `CMD5_ASSERT_NEXT(a_tail_delivered, link[ROUNDS].valid && advance, m_tvalid)
    // a held output freezes the end of the chain
    `CMD5_ASSERT_NEXT(a_tail_frozen, !advance, $stable(link[ROUNDS]))

endmodule

### sv/cmd5_cell.sv
module cmd5_cell
    import cmd5_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  round_cfg_t rcfg,
    input  msg_cfg_t   mcfg,
    input  stage_t     stage_in,
    output stage_t     stage_out
);

    logic        valid_reg;
    md5_state_t  state_reg;
    md5_state_t  state_next;
    logic [31:0] f;
    logic [31:0] m_word;
    logic [31:0] sum;

    always_comb begin
        unique case (rcfg.fn)
            FN_F:    f = (stage_in.st.b & stage_in.st.c) | (~stage_in.st.b & stage_in.st.d);
            FN_G:    f = (stage_in.st.d & stage_in.st.b) | (~stage_in.st.d & stage_in.st.c);
            FN_H:    f = stage_in.st.b ^ stage_in.st.c ^ stage_in.st.d;
            FN_I:    f = stage_in.st.c ^ (stage_in.st.b | ~stage_in.st.d);
            default: f = '0;
        endcase
        m_word = msg_word(mcfg, stage_in.st.secret, rcfg.g);
        sum    = stage_in.st.a + f + rcfg.k + m_word;

        // rotate the working words one place
        state_next.a      = stage_in.st.d;
        state_next.b      = stage_in.st.b + rotl32(sum, rcfg.shift);
        state_next.c      = stage_in.st.b;
        state_next.d      = stage_in.st.c;
        state_next.secret = stage_in.st.secret;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            state_reg <= state_next;
        end
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.st    = state_reg;

endmodule

### tb/chap_md5_response_check_tb.sv
`timescale 1ns / 100ps

module chap_md5_response_check_tb;
    import cmd5_pkg::*;

    localparam int PIPE_LATENCY   = 65;    // 64 round cells plus the output register
    localparam int MAX_GAP        = 16;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on any channel
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 60;
    localparam int MESSAGE_LEN    = 25;    // identifier, eight secret bytes, sixteen challenge bytes

    // indexes past the register map, writes to them must be dropped
    localparam logic [2:0] IDX_SPARE_LO = 3'd5;
    localparam logic [2:0] IDX_SPARE_HI = 3'd7;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam int ROT_AMOUNT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                       4, 11, 16, 23, 6, 10, 15, 21};

    typedef enum logic [1:0] {
        ROW_SECRET,  // one candidate secret
        ROW_WRITE,   // one register write
        ROW_ARM      // load the expected response with the digest of the given secret
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  index;
        logic [63:0] value;
        logic        known;   // matched flag typed in below
        logic        match;
    } stim_row_t;

    typedef struct {
        logic        matched;
        logic [63:0] digest_high;
        logic [63:0] digest_low;
        logic        match_known;
        logic        match_typed;
    } digest_result_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // [63:0] secret
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // [63:0] digest_high, [127:64] digest_low
    logic         m_tuser;   // [0] matched

    // directed rows; the index field of a secret row is unused
    stim_row_t directed [22] = '{
        '{ROW_SECRET, REG_IDENTIFIER,     64'h0000_0000_0000_0000, 1'b1, 1'b0},
        '{ROW_SECRET, REG_IDENTIFIER,     64'hffff_ffff_ffff_ffff, 1'b1, 1'b0},
        '{ROW_SECRET, REG_IDENTIFIER,     64'h0123_4567_89ab_cdef, 1'b1, 1'b0},
        '{ROW_SECRET, REG_IDENTIFIER,     64'h8000_0000_0000_0001, 1'b1, 1'b0},
        '{ROW_WRITE,  REG_IDENTIFIER,     64'hffff_ffff_ffff_ffff, 1'b0, 1'b0},
        '{ROW_WRITE,  REG_CHALLENGE_HIGH, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0},
        '{ROW_WRITE,  REG_CHALLENGE_LOW,  64'hffff_ffff_ffff_ffff, 1'b0, 1'b0},
        '{ROW_SECRET, REG_IDENTIFIER,     64'h0000_0000_0000_0000, 1'b0, 1'b0},
        '{ROW_SECRET, REG_IDENTIFIER,     64'hffff_ffff_ffff_ffff, 1'b0, 1'b0},
        '{ROW_WRITE,  IDX_SPARE_LO,       64'h5555_5555_5555_5555, 1'b0, 1'b0},
        '{ROW_WRITE,  IDX_SPARE_HI,       64'hffff_ffff_ffff_ffff, 1'b0, 1'b0},
        '{ROW_SECRET, REG_IDENTIFIER,     64'ha5a5_a5a5_a5a5_a5a5, 1'b0, 1'b0},
        '{ROW_ARM,    REG_EXPECTED_HIGH,  64'h0011_2233_4455_6677, 1'b0, 1'b0},
        '{ROW_SECRET, REG_IDENTIFIER,     64'h0011_2233_4455_6677, 1'b1, 1'b1},
        '{ROW_SECRET, REG_IDENTIFIER,     64'h0011_2233_4455_6676, 1'b1, 1'b0},
        '{ROW_WRITE,  REG_EXPECTED_LOW,   64'h0000_0000_0000_0000, 1'b0, 1'b0},
        '{ROW_SECRET, REG_IDENTIFIER,     64'h0011_2233_4455_6677, 1'b1, 1'b0},
        '{ROW_WRITE,  REG_IDENTIFIER,     64'h1234_5678_9abc_de5a, 1'b0, 1'b0},
        '{ROW_WRITE,  REG_CHALLENGE_HIGH, 64'h0123_4567_89ab_cdef, 1'b0, 1'b0},
        '{ROW_WRITE,  REG_CHALLENGE_LOW,  64'hfedc_ba98_7654_3210, 1'b0, 1'b0},
        '{ROW_SECRET, REG_IDENTIFIER,     64'h5555_5555_5555_5555, 1'b0, 1'b0},
        '{ROW_SECRET, REG_IDENTIFIER,     64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0}
    };

    // mirror of the register file, updated on each accepted write
    logic [7:0]  cur_identifier;
    logic [63:0] cur_challenge_high;
    logic [63:0] cur_challenge_low;
    logic [63:0] cur_expected_high;
    logic [63:0] cur_expected_low;

    logic [31:0]    sine_table [64];
    digest_result_t pending_digests [$];
    digest_result_t head;
    digest_result_t entry;
    logic [127:0]   calc;
    int             failures;
    int             stall_cycles;
    bit             quiet_phase;
    bit             settled;
    logic           row_known;
    logic           row_match;

    chap_md5_response_check DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] swap_bytes(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // md5 of identifier, secret and challenge as one padded block; {digest_high, digest_low}
    function automatic logic [127:0] chap_digest(input logic [7:0]  ident,
                                                 input logic [63:0] secret,
                                                 input logic [63:0] chal_high,
                                                 input logic [63:0] chal_low);
        logic [7:0]  msg [64];
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t, sum;
        int          g, sh;
        for (int p = 0; p < 64; p++) msg[p] = 8'h00;
        msg[0] = ident;
        for (int i = 0; i < 8; i++) begin
            msg[1 + i]  = secret[63 - 8*i -: 8];
            msg[9 + i]  = chal_high[63 - 8*i -: 8];
            msg[17 + i] = chal_low[63 - 8*i -: 8];
        end
        msg[MESSAGE_LEN] = 8'h80;
        msg[56] = 8'(MESSAGE_LEN * 8);
        msg[57] = 8'((MESSAGE_LEN * 8) >> 8);
        for (int j = 0; j < 16; j++)
            w[j] = {msg[4*j + 3], msg[4*j + 2], msg[4*j + 1], msg[4*j]};
        a = IV_A; b = IV_B; c = IV_C; d = IV_D;
        for (int i = 0; i < 64; i++) begin
            case (i / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5*i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3*i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7*i) % 16;
                end
            endcase
            sum = a + f + sine_table[i] + w[g];
            sh  = ROT_AMOUNT[(i / 16) * 4 + i % 4];
            t = d;
            d = c;
            c = b;
            b = b + ((sum << sh) | (sum >> (32 - sh)));
            a = t;
        end
        a = a + IV_A; b = b + IV_B; c = c + IV_C; d = d + IV_D;
        return {swap_bytes(a), swap_bytes(b), swap_bytes(c), swap_bytes(d)};
    endfunction

    function automatic int draw_gap();
        return quiet_phase ? 0 : $urandom_range(MAX_GAP, 0);
    endfunction

    // zero, all ones or a random word, so the extremes turn up often
    function automatic logic [63:0] pick_word();
        case ($urandom_range(3, 0))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // accepted transactions: predict on the s side, compare on the m side
    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_identifier     = '0;
            cur_challenge_high = '0;
            cur_challenge_low  = '0;
            cur_expected_high  = '0;
            cur_expected_low   = '0;
        end
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IDENTIFIER:     cur_identifier     = cfg_data[7:0];
                    REG_CHALLENGE_HIGH: cur_challenge_high = cfg_data;
                    REG_CHALLENGE_LOW:  cur_challenge_low  = cfg_data;
                    REG_EXPECTED_HIGH:  cur_expected_high  = cfg_data;
                    REG_EXPECTED_LOW:   cur_expected_low   = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                calc = chap_digest(cur_identifier, s_tdata, cur_challenge_high,
                                   cur_challenge_low);
                entry.digest_high = calc[127:64];
                entry.digest_low  = calc[63:0];
                entry.matched     = (calc == {cur_expected_high, cur_expected_low});
                entry.match_known = row_known;
                entry.match_typed = row_match;
                pending_digests = {pending_digests, entry};
            end
            if (m_tvalid && m_tready) begin
                if (pending_digests.size() == 0) begin
                    $error("unexpected result, digest_high %h", m_tdata[63:0]);
                    failures++;
                end else begin
                    head = pending_digests.pop_front();
                    if (m_tuser !== head.matched) begin
                        $error("matched: expected %0b, actual %0b", head.matched, m_tuser);
                        failures++;
                    end
                    if (head.match_known && m_tuser !== head.match_typed) begin
                        $error("matched: expected %0b, actual %0b", head.match_typed, m_tuser);
                        failures++;
                    end
                    if (m_tdata[63:0] !== head.digest_high) begin
                        $error("digest_high: expected %h, actual %h", head.digest_high,
                               m_tdata[63:0]);
                        failures++;
                    end
                    if (m_tdata[127:64] !== head.digest_low) begin
                        $error("digest_low: expected %h, actual %h", head.digest_low,
                               m_tdata[127:64]);
                        failures++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("chap_md5_response_check_tb failed");
        $finish;
    end

    // result side back-pressure, a fresh stall drawn for every result
    initial begin : receiver
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    task automatic send_secret(input logic [63:0] secret, input logic known, input logic match);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= secret;
        row_known <= known;
        row_match <= match;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        settled = 1'b0;
    endtask

    // hold off the sender until every digest is back and the pipeline is empty
    task automatic settle();
        if (!settled) begin
            s_tvalid <= 1'b0;
            while (pending_digests.size() != 0) @(negedge aclk);
            repeat (PIPE_LATENCY + 5) @(negedge aclk);
            settled = 1'b1;
        end
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // expected response := digest of this secret under the current settings
    task automatic arm_response(input logic [63:0] secret);
        logic [127:0] d;
        d = chap_digest(cur_identifier, secret, cur_challenge_high, cur_challenge_low);
        write_reg(REG_EXPECTED_HIGH, d[127:64]);
        write_reg(REG_EXPECTED_LOW, d[63:0]);
    endtask

    initial begin : stimulus
        real         s;
        stim_row_t   row;
        logic [63:0] target;
        logic [63:0] secret;
        quiet_phase = 1'b0;
        settled   = 1'b1;
        row_known = 1'b0;
        row_match = 1'b0;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;

        // round constants from the integer part of |sin(i+1)| * 2^32
        for (int i = 0; i < 64; i++) begin
            s = $sin(i + 1);
            if (s < 0.0) s = -s;
            sine_table[i] = 32'(longint'($floor(s * 4294967296.0)));
        end

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        for (int r = 0; r < $size(directed); r++) begin
            row = directed[r];
            case (row.kind)
                ROW_SECRET: send_secret(row.value, row.known, row.match);
                ROW_WRITE: begin
                    settle();
                    write_reg(row.index, row.value);
                end
                ROW_ARM: begin
                    settle();
                    arm_response(row.value);
                end
                default: ;
            endcase
        end

        // random phases, each with fresh settings; first all ones, then all zeros
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            quiet_phase = (ph % 3 == 1);
            if (ph == 0) begin
                write_reg(REG_IDENTIFIER, '1);
                write_reg(REG_CHALLENGE_HIGH, '1);
                write_reg(REG_CHALLENGE_LOW, '1);
            end else if (ph == 1) begin
                write_reg(REG_IDENTIFIER, 64'h0);
                write_reg(REG_CHALLENGE_HIGH, 64'h0);
                write_reg(REG_CHALLENGE_LOW, 64'h0);
            end else begin
                write_reg(REG_IDENTIFIER, pick_word());
                write_reg(REG_CHALLENGE_HIGH, pick_word());
                write_reg(REG_CHALLENGE_LOW, pick_word());
            end
            if ($urandom_range(1, 0))
                write_reg(3'($urandom_range(IDX_SPARE_HI, IDX_SPARE_LO)), {$urandom, $urandom});
            target = pick_word();
            if ($urandom_range(3, 0) != 0) begin
                arm_response(target);
            end else begin
                write_reg(REG_EXPECTED_HIGH, pick_word());
                write_reg(REG_EXPECTED_LOW, pick_word());
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // one pause mid-run with the whole pipeline drained
                if (ph == RANDOM_PHASES / 2 && n == PHASE_ITEMS / 2)
                    settle();
                case ($urandom_range(15, 0))
                    0, 1:    secret = target;
                    2:       secret = target ^ (64'd1 << $urandom_range(63, 0));
                    3:       secret = pick_word();
                    default: secret = {$urandom, $urandom};
                endcase
                send_secret(secret, 1'b0, 1'b0);
            end
        end

        settle();
        if (failures == 0)
            $display("chap_md5_response_check_tb passed");
        else
            $display("chap_md5_response_check_tb failed");
        $finish;
    end

endmodule
